>>> rtl/core/elpa_pkg.sv
// elpa_pkg: shared widths, constants, register indexes and the config struct
// for the ellipse pixel accumulator; used by every module under rtl/core
package elpa_pkg;

	// pixel fields
	localparam int ROW_W  = 10;
	localparam int PIX_W  = 22;
	localparam int ACC_W  = PIX_W + 1;
	localparam int MAX_SIDE = 1024;

	// config port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 22;

	// register widths
	localparam int STEP_W = 18;
	localparam int CTR_W  = 19;
	localparam int AXIS_W = 18;
	localparam int TRIG_W = 18;

	// datapath widths
	localparam int XPROD_W = ROW_W + STEP_W;      // col * step
	localparam int DIFF_W  = XPROD_W + 2;         // shifted, centered coordinate
	localparam int ROTP_W  = DIFF_W + TRIG_W;     // one rotation product, Q.32
	localparam int ROTS_W  = ROTP_W + 1;          // sum of two products
	localparam int ROT_W   = ROTS_W - 16;         // rotated coordinate, Q.16
	localparam int HALF_W  = 2 * AXIS_W;          // ax*b, ay*a, a*b
	localparam int SQ_W    = 2 * HALF_W;          // squares of those
	localparam int SUM_W   = SQ_W + 1;

	localparam logic signed [DIFF_W-1:0] ONE_Q16  = DIFF_W'(65536);
	localparam logic signed [ROTS_W-1:0] HALF_Q16 = ROTS_W'(32768);
	localparam logic signed [ACC_W-1:0]  PIX_MAX  = ACC_W'(1048576);
	localparam logic signed [ACC_W-1:0]  PIX_MIN  = -ACC_W'(1048576);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PIXEL_STEP   = 3'd0,
		REG_CENTER_X     = 3'd1,
		REG_CENTER_Y     = 3'd2,
		REG_SEMI_AXIS_X  = 3'd3,
		REG_SEMI_AXIS_Y  = 3'd4,
		REG_COS_ANGLE    = 3'd5,
		REG_SIN_ANGLE    = 3'd6,
		REG_ELLIPSE_VAL  = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic        [STEP_W-1:0] pixel_step;
		logic signed [CTR_W-1:0]  center_x;
		logic signed [CTR_W-1:0]  center_y;
		logic        [AXIS_W-1:0] semi_axis_x;
		logic        [AXIS_W-1:0] semi_axis_y;
		logic signed [TRIG_W-1:0] cos_angle;
		logic signed [TRIG_W-1:0] sin_angle;
		logic signed [PIX_W-1:0]  intensity;
	} cfg_t;

endpackage

>>> rtl/core/elpa_rotate.sv
// elpa_rotate: stages 1 to 3, pixel index to plane coordinate, centering and
// rotation into the ellipse frame; depends on elpa_pkg
module elpa_rotate import elpa_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cfg_t                     cfg,
	input  logic                     v_in,
	output logic                     rdy,
	input  logic [ROW_W-1:0]         pixel_row,
	input  logic [ROW_W-1:0]         pixel_col,
	input  logic signed [PIX_W-1:0]  pixel_in,
	input  logic                     en_next,
	output logic                     v_out,
	output logic signed [ROT_W-1:0]  xr,
	output logic signed [ROT_W-1:0]  yr,
	output logic                     oob,
	output logic signed [PIX_W-1:0]  pix
);

	logic v_s1, v_s2, v_s3;
	logic en1, en2, en3;

	logic [XPROD_W-1:0]       xprod, yprod;
	logic signed [DIFF_W-1:0] x, y, dx, dy;
	logic signed [ROTS_W-1:0] sum_x, sum_y;

	logic signed [DIFF_W-1:0] dx_s1, dy_s1;
	logic                     oob_s1, oob_s2, oob_s3;
	logic signed [PIX_W-1:0]  pix_s1, pix_s2, pix_s3;
	logic signed [ROTP_W-1:0] pxc_s2, pys_s2, pyc_s2, pxs_s2;
	logic signed [ROT_W-1:0]  xr_s3, yr_s3;

	assign en3 = !v_s3 || en_next;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign rdy = en1;

	always_comb begin
		xprod = XPROD_W'(pixel_col) * XPROD_W'(cfg.pixel_step);
		yprod = XPROD_W'(pixel_row) * XPROD_W'(cfg.pixel_step);
		x     = $signed({2'b00, xprod}) - ONE_Q16;
		y     = $signed({2'b00, yprod}) - ONE_Q16;
		dx    = x - DIFF_W'(cfg.center_x);
		dy    = y - DIFF_W'(cfg.center_y);
	end

	// rounding to nearest, ties up, is an arithmetic shift after adding half
	always_comb begin
		sum_x = ROTS_W'(pxc_s2) + ROTS_W'(pys_s2) + HALF_Q16;
		sum_y = ROTS_W'(pyc_s2) - ROTS_W'(pxs_s2) + HALF_Q16;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= v_in;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			dx_s1  <= dx;
			dy_s1  <= dy;
			oob_s1 <= (13'(pixel_row) >= 13'(MAX_SIDE)) || (13'(pixel_col) >= 13'(MAX_SIDE));
			pix_s1 <= pixel_in;
		end
		if (en2) begin
			pxc_s2 <= ROTP_W'(dx_s1) * ROTP_W'(cfg.cos_angle);
			pys_s2 <= ROTP_W'(dy_s1) * ROTP_W'(cfg.sin_angle);
			pyc_s2 <= ROTP_W'(dy_s1) * ROTP_W'(cfg.cos_angle);
			pxs_s2 <= ROTP_W'(dx_s1) * ROTP_W'(cfg.sin_angle);
			oob_s2 <= oob_s1;
			pix_s2 <= pix_s1;
		end
		if (en3) begin
			xr_s3  <= sum_x[ROTS_W-1:16];
			yr_s3  <= sum_y[ROTS_W-1:16];
			oob_s3 <= oob_s2;
			pix_s3 <= pix_s2;
		end
	end

	assign v_out = v_s3;
	assign xr    = xr_s3;
	assign yr    = yr_s3;
	assign oob   = oob_s3;
	assign pix   = pix_s3;

endmodule

>>> rtl/core/elpa_test.sv
// elpa_test: stages 4 to 8, the division-free inside test
// (ax*b)^2 + (ay*a)^2 <= (a*b)^2 built from 18x18 products; depends on elpa_pkg
module elpa_test import elpa_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cfg_t                     cfg,
	input  logic                     v_in,
	output logic                     rdy,
	input  logic signed [ROT_W-1:0]  xr,
	input  logic signed [ROT_W-1:0]  yr,
	input  logic                     oob,
	input  logic signed [PIX_W-1:0]  pix,
	input  logic                     en_next,
	output logic                     v_out,
	output logic                     hit,
	output logic signed [PIX_W-1:0]  pix_out
);

	localparam int HH = HALF_W / 2;

	logic v_s4, v_s5, v_s6, v_s7, v_s8;
	logic en4, en5, en6, en7, en8;

	logic [ROT_W-1:0] ax, ay;
	logic             far;

	logic [AXIS_W-1:0]       ax_s4, ay_s4;
	logic                    far_s4, far_s5, far_s6, far_s7;
	logic signed [PIX_W-1:0] pix_s4, pix_s5, pix_s6, pix_s7, pix_s8;
	logic [HALF_W-1:0]       u_s5, v_s5_d, w_s5;
	logic [HALF_W-1:0]       uhh_s6, uhl_s6, ull_s6;
	logic [HALF_W-1:0]       vhh_s6, vhl_s6, vll_s6;
	logic [HALF_W-1:0]       whh_s6, whl_s6, wll_s6;
	logic [SQ_W-1:0]         u2_s7, v2_s7, w2_s7;
	logic                    inside_s8;

	assign en8 = !v_s8 || en_next;
	assign en7 = !v_s7 || en8;
	assign en6 = !v_s6 || en7;
	assign en5 = !v_s5 || en6;
	assign en4 = !v_s4 || en5;
	assign rdy = en4;

	// a coordinate beyond its semi-axis is outside on its own, which keeps
	// the remaining magnitudes within the axis width
	always_comb begin
		ax  = xr[ROT_W-1] ? ROT_W'(-xr) : ROT_W'(xr);
		ay  = yr[ROT_W-1] ? ROT_W'(-yr) : ROT_W'(yr);
		far = oob || (cfg.semi_axis_x == '0) || (cfg.semi_axis_y == '0) ||
			(ax > ROT_W'(cfg.semi_axis_x)) || (ay > ROT_W'(cfg.semi_axis_y));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			if (en4) v_s4 <= v_in;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
			if (en7) v_s7 <= v_s6;
			if (en8) v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			ax_s4  <= ax[AXIS_W-1:0];
			ay_s4  <= ay[AXIS_W-1:0];
			far_s4 <= far;
			pix_s4 <= pix;
		end
		if (en5) begin
			u_s5   <= HALF_W'(ax_s4) * HALF_W'(cfg.semi_axis_y);
			v_s5_d <= HALF_W'(ay_s4) * HALF_W'(cfg.semi_axis_x);
			w_s5   <= HALF_W'(cfg.semi_axis_x) * HALF_W'(cfg.semi_axis_y);
			far_s5 <= far_s4;
			pix_s5 <= pix_s4;
		end
		// squares split into high and low halves
		if (en6) begin
			uhh_s6 <= HALF_W'(u_s5[HALF_W-1:HH]) * HALF_W'(u_s5[HALF_W-1:HH]);
			uhl_s6 <= HALF_W'(u_s5[HALF_W-1:HH]) * HALF_W'(u_s5[HH-1:0]);
			ull_s6 <= HALF_W'(u_s5[HH-1:0]) * HALF_W'(u_s5[HH-1:0]);
			vhh_s6 <= HALF_W'(v_s5_d[HALF_W-1:HH]) * HALF_W'(v_s5_d[HALF_W-1:HH]);
			vhl_s6 <= HALF_W'(v_s5_d[HALF_W-1:HH]) * HALF_W'(v_s5_d[HH-1:0]);
			vll_s6 <= HALF_W'(v_s5_d[HH-1:0]) * HALF_W'(v_s5_d[HH-1:0]);
			whh_s6 <= HALF_W'(w_s5[HALF_W-1:HH]) * HALF_W'(w_s5[HALF_W-1:HH]);
			whl_s6 <= HALF_W'(w_s5[HALF_W-1:HH]) * HALF_W'(w_s5[HH-1:0]);
			wll_s6 <= HALF_W'(w_s5[HH-1:0]) * HALF_W'(w_s5[HH-1:0]);
			far_s6 <= far_s5;
			pix_s6 <= pix_s5;
		end
		if (en7) begin
			u2_s7  <= {uhh_s6, HALF_W'(0)} + (SQ_W'(uhl_s6) << (HH + 1)) + SQ_W'(ull_s6);
			v2_s7  <= {vhh_s6, HALF_W'(0)} + (SQ_W'(vhl_s6) << (HH + 1)) + SQ_W'(vll_s6);
			w2_s7  <= {whh_s6, HALF_W'(0)} + (SQ_W'(whl_s6) << (HH + 1)) + SQ_W'(wll_s6);
			far_s7 <= far_s6;
			pix_s7 <= pix_s6;
		end
		if (en8) begin
			inside_s8 <= !far_s7 && ((SUM_W'(u2_s7) + SUM_W'(v2_s7)) <= SUM_W'(w2_s7));
			pix_s8    <= pix_s7;
		end
	end

	assign v_out   = v_s8;
	assign hit     = inside_s8;
	assign pix_out = pix_s8;

endmodule

>>> rtl/core/ellipse_pixel_accumulate.sv
// ellipse_pixel_accumulate: top level, config registers, the two datapath
// sections and the saturating output stage; depends on elpa_pkg, elpa_rotate, elpa_test
// an accepted input word passes the rotate and test sections, then the output register
// throughput: one word per cycle; a stage holds only while the one after it is full and held
// reset clears all valid bits and loads the default ellipse (unit circle, value 1.0)
module ellipse_pixel_accumulate import elpa_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_data,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [ROW_W-1:0]         pixel_row,
	input  logic [ROW_W-1:0]         pixel_col,
	input  logic signed [PIX_W-1:0]  pixel_in,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [PIX_W-1:0]  pixel_out,
	output logic                     inside_flag
);

	cfg_t cfg_q;

	logic                    rot_rdy, rot_v, tst_rdy, tst_v, tst_inside, oob;
	logic signed [ROT_W-1:0] xr, yr;
	logic signed [PIX_W-1:0] rot_pix, tst_pix;

	logic                    v_s9, en9;
	logic signed [PIX_W-1:0] pixel_out_s9;
	logic                    inside_s9;
	logic signed [ACC_W-1:0] acc, acc_sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pixel_step    <= STEP_W'(514);
			cfg_q.center_x      <= '0;
			cfg_q.center_y      <= '0;
			cfg_q.semi_axis_x   <= AXIS_W'(65536);
			cfg_q.semi_axis_y   <= AXIS_W'(65536);
			cfg_q.cos_angle     <= TRIG_W'(65536);
			cfg_q.sin_angle     <= '0;
			cfg_q.intensity     <= PIX_W'(65536);
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				REG_PIXEL_STEP:  cfg_q.pixel_step    <= cfg_data[STEP_W-1:0];
				REG_CENTER_X:    cfg_q.center_x      <= cfg_data[CTR_W-1:0];
				REG_CENTER_Y:    cfg_q.center_y      <= cfg_data[CTR_W-1:0];
				REG_SEMI_AXIS_X: cfg_q.semi_axis_x   <= cfg_data[AXIS_W-1:0];
				REG_SEMI_AXIS_Y: cfg_q.semi_axis_y   <= cfg_data[AXIS_W-1:0];
				REG_COS_ANGLE:   cfg_q.cos_angle     <= cfg_data[TRIG_W-1:0];
				REG_SIN_ANGLE:   cfg_q.sin_angle     <= cfg_data[TRIG_W-1:0];
				REG_ELLIPSE_VAL: cfg_q.intensity     <= cfg_data[PIX_W-1:0];
				default: ;
			endcase
		end
	end

	elpa_rotate u_rotate (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.v_in      (in_valid),
		.rdy       (rot_rdy),
		.pixel_row (pixel_row),
		.pixel_col (pixel_col),
		.pixel_in  (pixel_in),
		.en_next   (tst_rdy),
		.v_out     (rot_v),
		.xr        (xr),
		.yr        (yr),
		.oob       (oob),
		.pix       (rot_pix)
	);

	elpa_test u_test (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.v_in    (rot_v),
		.rdy     (tst_rdy),
		.xr      (xr),
		.yr      (yr),
		.oob     (oob),
		.pix     (rot_pix),
		.en_next (en9),
		.v_out   (tst_v),
		.hit     (tst_inside),
		.pix_out (tst_pix)
	);

	assign in_stall = !rot_rdy;
	assign en9      = !v_s9 || !out_stall;

	always_comb begin
		acc = ACC_W'(tst_pix) + (tst_inside ? ACC_W'(cfg_q.intensity) : ACC_W'(0));
		if (acc > PIX_MAX)
			acc_sat = PIX_MAX;
		else if (acc < PIX_MIN)
			acc_sat = PIX_MIN;
		else
			acc_sat = acc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else if (en9) begin
			v_s9 <= tst_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en9) begin
			pixel_out_s9 <= acc_sat[PIX_W-1:0];
			inside_s9    <= tst_inside;
		end
	end

	assign out_valid   = v_s9;
	assign pixel_out   = pixel_out_s9;
	assign inside_flag = inside_s9;

`ifndef SYNTHESIS
	// the input side only backs up when the whole pipe is full and stalled
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled while the pipe has room");

	// a zero semi-axis never yields a hit
	a_zero_axis_outside: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && ((cfg_q.semi_axis_x == '0) || (cfg_q.semi_axis_y == '0)))
		|-> !inside_flag)
		else $error("hit reported with a zero semi-axis");

	// output word stays within the saturation range
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((ACC_W'(pixel_out) <= PIX_MAX) && (ACC_W'(pixel_out) >= PIX_MIN)))
		else $error("output word outside the saturation range");
`endif

endmodule
